@@ rtl/tbo_pkg.sv @@
package tbo_pkg;

    // Width of the configuration register index.
    localparam int CFG_IDX_W = 3;

    // Configuration register map.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X = 3'd0,
        CFG_CENTER_Y = 3'd1,
        CFG_CENTER_Z = 3'd2,
        CFG_HALF_X   = 3'd3,
        CFG_HALF_Y   = 3'd4,
        CFG_HALF_Z   = 3'd5
    } cfg_reg_t;

endpackage

@@ rtl/triangle_box_overlap_test.sv @@
// Triangle against axis-aligned box overlap test by the separating axis theorem, in exact
// signed fixed point. The box centre and half extents are held in six configuration
// registers written through the cfg_ port (centre x, y, z, then half x, y, z); they must
// only be changed while no beat is in flight. Each input beat carries the three vertices
// of one triangle and yields exactly one output beat whose bit 0 is 1 when the triangle
// and the box overlap or touch. The test is a seven-stage pipeline: a new triangle is
// accepted in every cycle unless back-pressure has filled the pipeline. Its result
// passes through the registers of stages 1 to 7 before it can leave. The depth is set by
// the registered multiplier stages of the normal-axis test, whose wide products are cut
// into two partial products each. Every stage carries its own valid bit and only waits
// when the stage after it is full and stalled, so bubbles close up under back-pressure.
module triangle_box_overlap_test #(
    parameter int COORD_BITS = 24,
    localparam int IN_W      = ((9 * COORD_BITS + 7) / 8) * 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration write port.
    input  logic                           cfg_we,
    input  logic [tbo_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [COORD_BITS-1:0]          cfg_data,
    // Input stream.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // Fields from bit 0 up: a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z.
    input  logic [IN_W-1:0]                s_tdata,
    // Result stream.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // Fields from bit 0 up: overlaps, then zero padding.
    output logic [7:0]                     m_tdata
);
    import tbo_pkg::*;

    localparam int N   = COORD_BITS;
    localparam int VW  = N + 1;           // shifted vertex and edge width
    localparam int PW  = 2 * N + 2;       // edge times vertex product
    localparam int RW  = 2 * N - 1;       // |edge| times half extent
    localparam int SW  = 2 * N + 5;       // edge-axis projection and radius
    localparam int NW  = 2 * N + 3;       // normal component
    localparam int SPL = N + 2;           // split point of the normal components
    localparam int HIW = NW - SPL;        // signed upper part of a normal component
    localparam int DLW = SPL + 1 + VW;    // lower partial product on the vertex
    localparam int DHW = HIW + VW;        // upper partial product on the vertex
    localparam int RLW = SPL + N - 1;     // lower partial product on the half extent
    localparam int RHW = (HIW - 1) + N - 1;
    localparam int DW  = 3 * N + 6;       // normal projection and radius

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic signed [N-1:0] center_reg [3];
    logic        [N-2:0] half_reg   [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int q = 0; q < 3; q++) begin
                center_reg[q] <= '0;
                half_reg[q]   <= '0;
            end
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_CENTER_X: center_reg[0] <= cfg_data;
                CFG_CENTER_Y: center_reg[1] <= cfg_data;
                CFG_CENTER_Z: center_reg[2] <= cfg_data;
                CFG_HALF_X:   half_reg[0]   <= cfg_data[N-2:0];
                CFG_HALF_Y:   half_reg[1]   <= cfg_data[N-2:0];
                CFG_HALF_Z:   half_reg[2]   <= cfg_data[N-2:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control. A stage takes a new beat when it is empty or
    // when the stage after it is taking its current one.
    // ------------------------------------------------------------------
    logic [7:1] vld_reg;
    logic [7:1] adv;

    always_comb begin
        adv[7] = !vld_reg[7] || m_tready;
        for (int k = 6; k >= 1; k--) begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (adv[1]) begin
                vld_reg[1] <= s_tvalid;
            end
            for (int k = 2; k <= 7; k++) begin
                if (adv[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    assign s_tready = adv[1];
    assign m_tvalid = vld_reg[7];

    // ------------------------------------------------------------------
    // Stage 1: shift the vertices by the box centre and form the edges.
    // Edges come from the raw vertices, since the centre cancels.
    // ------------------------------------------------------------------
    logic signed [N-1:0]  vin        [3][3];
    logic signed [VW-1:0] v1_next    [3][3];
    logic signed [VW-1:0] e1_next    [3][3];
    logic        [N-1:0]  ea1_next   [3][3];
    logic signed [VW-1:0] v1_reg     [3][3];
    logic signed [VW-1:0] e1_reg     [3][3];
    logic        [N-1:0]  ea1_reg    [3][3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int q = 0; q < 3; q++) begin
                vin[i][q]     = s_tdata[(3 * i + q) * N +: N];
                v1_next[i][q] = VW'(vin[i][q]) - VW'(center_reg[q]);
            end
        end
        for (int q = 0; q < 3; q++) begin
            e1_next[0][q] = VW'(vin[1][q]) - VW'(vin[0][q]);
            e1_next[1][q] = VW'(vin[2][q]) - VW'(vin[1][q]);
            e1_next[2][q] = VW'(vin[0][q]) - VW'(vin[2][q]);
        end
        for (int i = 0; i < 3; i++) begin
            for (int q = 0; q < 3; q++) begin
                ea1_next[i][q] = e1_next[i][q][VW-1] ? N'(-e1_next[i][q]) : N'(e1_next[i][q]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            v1_reg  <= v1_next;
            e1_reg  <= e1_next;
            ea1_reg <= ea1_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: products of the edge-axis tests, products of the normal,
    // and the three box-axis tests, which need no multiplier.
    // For edge i crossed with axis k the axis vector has e[k2] at k1 and
    // -e[k1] at k2. Vertices i and i+1 project to the same value, so only
    // vertex i and vertex i+2 are projected.
    // ------------------------------------------------------------------
    logic signed [PW-1:0]  pa2_next [3][3][2];
    logic signed [PW-1:0]  pb2_next [3][3][2];
    logic        [RW-1:0]  ra2_next [3][3];
    logic        [RW-1:0]  rb2_next [3][3];
    logic signed [PW-1:0]  np2_next [3][2];
    logic                  box_sep2_next;
    logic signed [PW-1:0]  pa2_reg  [3][3][2];
    logic signed [PW-1:0]  pb2_reg  [3][3][2];
    logic        [RW-1:0]  ra2_reg  [3][3];
    logic        [RW-1:0]  rb2_reg  [3][3];
    logic signed [PW-1:0]  np2_reg  [3][2];
    logic signed [VW-1:0]  v02_reg  [3];
    logic                  box_sep2_reg;

    for (genvar gi = 0; gi < 3; gi++) begin : g_edge
        for (genvar gk = 0; gk < 3; gk++) begin : g_axis
            localparam int K1 = (gk + 1) % 3;
            localparam int K2 = (gk + 2) % 3;
            localparam int J2 = (gi + 2) % 3;
            assign pa2_next[gi][gk][0] = PW'(e1_reg[gi][K2]) * PW'(v1_reg[gi][K1]);
            assign pb2_next[gi][gk][0] = PW'(e1_reg[gi][K1]) * PW'(v1_reg[gi][K2]);
            assign pa2_next[gi][gk][1] = PW'(e1_reg[gi][K2]) * PW'(v1_reg[J2][K1]);
            assign pb2_next[gi][gk][1] = PW'(e1_reg[gi][K1]) * PW'(v1_reg[J2][K2]);
            assign ra2_next[gi][gk]    = RW'(ea1_reg[gi][K2]) * RW'(half_reg[K1]);
            assign rb2_next[gi][gk]    = RW'(ea1_reg[gi][K1]) * RW'(half_reg[K2]);
        end
    end

    // Normal is edge 0 crossed with edge 1.
    for (genvar gq = 0; gq < 3; gq++) begin : g_norm
        localparam int Q1 = (gq + 1) % 3;
        localparam int Q2 = (gq + 2) % 3;
        assign np2_next[gq][0] = PW'(e1_reg[0][Q1]) * PW'(e1_reg[1][Q2]);
        assign np2_next[gq][1] = PW'(e1_reg[0][Q2]) * PW'(e1_reg[1][Q1]);
    end

    always_comb begin
        logic signed [VW-1:0] vmin;
        logic signed [VW-1:0] vmax;
        logic signed [VW-1:0] hs;
        box_sep2_next = 1'b0;
        for (int q = 0; q < 3; q++) begin
            vmin = v1_reg[0][q];
            vmax = v1_reg[0][q];
            for (int i = 1; i < 3; i++) begin
                if (v1_reg[i][q] < vmin) begin
                    vmin = v1_reg[i][q];
                end
                if (v1_reg[i][q] > vmax) begin
                    vmax = v1_reg[i][q];
                end
            end
            hs = $signed({2'b00, half_reg[q]});
            if (vmin > hs || vmax < -hs) begin
                box_sep2_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            pa2_reg      <= pa2_next;
            pb2_reg      <= pb2_next;
            ra2_reg      <= ra2_next;
            rb2_reg      <= rb2_next;
            np2_reg      <= np2_next;
            v02_reg      <= v1_reg[0];
            box_sep2_reg <= box_sep2_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: finish the edge-axis tests of every edge against every axis, and the normal components.
    // ------------------------------------------------------------------
    logic                  sep3_next;
    logic signed [NW-1:0]  n3_next  [3];
    logic                  sep3_reg;
    logic signed [NW-1:0]  n3_reg   [3];
    logic signed [VW-1:0]  v03_reg  [3];

    always_comb begin
        logic signed [SW-1:0] p0;
        logic signed [SW-1:0] p1;
        logic signed [SW-1:0] plo;
        logic signed [SW-1:0] phi;
        logic signed [SW-1:0] r;
        sep3_next = box_sep2_reg;
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                p0 = SW'(pa2_reg[i][k][0]) - SW'(pb2_reg[i][k][0]);
                p1 = SW'(pa2_reg[i][k][1]) - SW'(pb2_reg[i][k][1]);
                r  = $signed(SW'(ra2_reg[i][k])) + $signed(SW'(rb2_reg[i][k]));
                plo = (p1 < p0) ? p1 : p0;
                phi = (p1 < p0) ? p0 : p1;
                if (plo > r || phi < -r) begin
                    sep3_next = 1'b1;
                end
            end
        end
        for (int q = 0; q < 3; q++) begin
            n3_next[q] = NW'(np2_reg[q][0]) - NW'(np2_reg[q][1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[3]) begin
            sep3_reg <= sep3_next;
            n3_reg   <= n3_next;
            v03_reg  <= v02_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: magnitude of the normal components.
    // ------------------------------------------------------------------
    logic        [NW-2:0]  an4_next [3];
    logic                  sep4_reg;
    logic signed [NW-1:0]  n4_reg   [3];
    logic        [NW-2:0]  an4_reg  [3];
    logic signed [VW-1:0]  v04_reg  [3];

    always_comb begin
        for (int q = 0; q < 3; q++) begin
            an4_next[q] = n3_reg[q][NW-1] ? (NW-1)'(-n3_reg[q]) : n3_reg[q][NW-2:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[4]) begin
            sep4_reg <= sep3_reg;
            n4_reg   <= n3_reg;
            an4_reg  <= an4_next;
            v04_reg  <= v03_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: partial products of the normal projection of vertex 0 (all
    // three vertices project alike onto the normal) and of the radius.
    // ------------------------------------------------------------------
    logic signed [DLW-1:0] dlo5_next [3];
    logic signed [DHW-1:0] dhi5_next [3];
    logic        [RLW-1:0] rlo5_next [3];
    logic        [RHW-1:0] rhi5_next [3];
    logic                  sep5_reg;
    logic signed [DLW-1:0] dlo5_reg  [3];
    logic signed [DHW-1:0] dhi5_reg  [3];
    logic        [RLW-1:0] rlo5_reg  [3];
    logic        [RHW-1:0] rhi5_reg  [3];

    always_comb begin
        for (int q = 0; q < 3; q++) begin
            dlo5_next[q] = DLW'($signed({1'b0, n4_reg[q][SPL-1:0]})) * DLW'(v04_reg[q]);
            dhi5_next[q] = DHW'($signed(n4_reg[q][NW-1:SPL])) * DHW'(v04_reg[q]);
            rlo5_next[q] = RLW'(an4_reg[q][SPL-1:0]) * RLW'(half_reg[q]);
            rhi5_next[q] = RHW'(an4_reg[q][NW-2:SPL]) * RHW'(half_reg[q]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[5]) begin
            sep5_reg <= sep4_reg;
            dlo5_reg <= dlo5_next;
            dhi5_reg <= dhi5_next;
            rlo5_reg <= rlo5_next;
            rhi5_reg <= rhi5_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: recombine the partial products into projection and radius.
    // ------------------------------------------------------------------
    logic signed [DW-1:0] d6_next;
    logic signed [DW-1:0] r6_next;
    logic                 sep6_reg;
    logic signed [DW-1:0] d6_reg;
    logic signed [DW-1:0] r6_reg;

    always_comb begin
        d6_next = '0;
        r6_next = '0;
        for (int q = 0; q < 3; q++) begin
            d6_next = d6_next + (DW'(dhi5_reg[q]) <<< SPL) + DW'(dlo5_reg[q]);
            r6_next = r6_next + ($signed(DW'(rhi5_reg[q])) <<< SPL)
                              + $signed(DW'(rlo5_reg[q]));
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[6]) begin
            sep6_reg <= sep5_reg;
            d6_reg   <= d6_next;
            r6_reg   <= r6_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: normal-axis comparison and the output register.
    // ------------------------------------------------------------------
    logic overlaps_next;
    logic overlaps_reg;

    assign overlaps_next = !(sep6_reg || d6_reg > r6_reg || d6_reg < -r6_reg);

    always_ff @(posedge aclk) begin
        if (adv[7]) begin
            overlaps_reg <= overlaps_next;
        end
    end

    assign m_tdata = {7'b0, overlaps_reg};

endmodule
